@@ rtl/mms_pkg.sv @@
// mms_pkg: types and constants shared by the motor mode sequencer modules
// no dependencies
`timescale 1ns / 1ps

package mms_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int TIME_W      = 64;
    localparam int RPM_W       = 16;
    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int KIND_W      = 3;
    localparam int COUNT_W     = 4;
    localparam int ARM_W       = 8;
    localparam int MODE_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_DURATION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_TTL    = 2'd1;

    localparam logic [CFG_W-1:0] START_DURATION_RESET = 32'd500000;
    localparam logic [CFG_W-1:0] COMMAND_TTL_RESET    = 32'd100000;

    localparam logic [ARM_W-1:0] ARM_DISARM = 8'd0;
    localparam logic [ARM_W-1:0] ARM_ARM    = 8'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK         = 3'd0,
        KIND_RPM_CMD      = 3'd1,
        KIND_CASC_CMD     = 3'd2,
        KIND_MOTOR_STATE  = 3'd3,
        KIND_GAINS_READY  = 3'd4,
        KIND_STATE_READY  = 3'd5,
        KIND_EXT_CMD      = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_RPM_CMD,
        OP_CASC_CMD,
        OP_ARM,
        OP_DISARM,
        OP_GAINS,
        OP_STATE,
        OP_EXT
    } op_t;

    typedef enum logic [2:0] {
        DRIVE_OFF   = 3'd0,
        DRIVE_START = 3'd1,
        DRIVE_MIN   = 3'd2,
        DRIVE_RPM   = 3'd3,
        DRIVE_CASC  = 3'd4,
        DRIVE_HOLD  = 3'd5
    } drive_t;

    typedef logic [MOTOR_COUNT-1:0][RPM_W-1:0] rpm_vec_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] time_us;
        rpm_vec_t          rpm;
    } item_t;

    typedef struct packed {
        drive_t            code;
        rpm_vec_t          rpm;
        logic [MODE_W-1:0] mode;
    } result_t;

endpackage

@@ rtl/motor_mode_sequencer.sv @@
// motor_mode_sequencer: top level, decode front, command queue, mode back end
// and result queue; depends on mms_pkg, mms_front, mms_queue, mms_back
// a taken tick beat is registered in the command queue, then in the result queue
// throughput: one beat per cycle while results are popped, set by the back-end step
// queue depths of at least 2 keep that rate; depth 1 halves it
// reset: rst_n async, clears both queues, mode, flags, registers; config to defaults
`timescale 1ns / 1ps

module motor_mode_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [mms_pkg::KIND_W-1:0]       kind,
    input  logic [mms_pkg::TIME_W-1:0]       time_now_us,
    input  logic [mms_pkg::COUNT_W-1:0]      input_count,
    input  logic [mms_pkg::RPM_W-1:0]        rpm_a,
    input  logic [mms_pkg::RPM_W-1:0]        rpm_b,
    input  logic [mms_pkg::RPM_W-1:0]        rpm_c,
    input  logic [mms_pkg::RPM_W-1:0]        rpm_d,
    input  logic [mms_pkg::ARM_W-1:0]        arm_value,
    output logic                             empty,
    input  logic                             pop,
    output logic [2:0]                       drive_code,
    output logic [mms_pkg::RPM_W-1:0]        out_rpm_a,
    output logic [mms_pkg::RPM_W-1:0]        out_rpm_b,
    output logic [mms_pkg::RPM_W-1:0]        out_rpm_c,
    output logic [mms_pkg::RPM_W-1:0]        out_rpm_d,
    output logic [mms_pkg::MODE_W-1:0]       mode_now,
    input  logic                             cfg_we,
    input  logic [mms_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mms_pkg::CFG_W-1:0]        cfg_data
);

    import mms_pkg::*;

    logic    cq_push;
    logic    cq_full;
    logic    cq_pop;
    logic    cq_empty;
    item_t   cq_in;
    item_t   cq_head;
    logic    rq_push;
    logic    rq_full;
    result_t rq_in;
    result_t rq_head;

    mms_front u_front (
        .push        (push),
        .full        (full),
        .kind        (kind),
        .time_now_us (time_now_us),
        .input_count (input_count),
        .rpm_a       (rpm_a),
        .rpm_b       (rpm_b),
        .rpm_c       (rpm_c),
        .rpm_d       (rpm_d),
        .arm_value   (arm_value),
        .q_full      (cq_full),
        .q_push      (cq_push),
        .q_item      (cq_in)
    );

    mms_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .item_t (item_t)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cq_push),
        .push_data (cq_in),
        .full      (cq_full),
        .pop       (cq_pop),
        .pop_data  (cq_head),
        .empty     (cq_empty)
    );

    mms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (cq_empty),
        .q_item    (cq_head),
        .q_pop     (cq_pop),
        .out_full  (rq_full),
        .out_push  (rq_push),
        .out_item  (rq_in)
    );

    mms_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .item_t (result_t)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rq_push),
        .push_data (rq_in),
        .full      (rq_full),
        .pop       (pop),
        .pop_data  (rq_head),
        .empty     (empty)
    );

    assign drive_code = rq_head.code;
    assign out_rpm_a  = rq_head.rpm[0];
    assign out_rpm_b  = rq_head.rpm[1];
    assign out_rpm_c  = rq_head.rpm[2];
    assign out_rpm_d  = rq_head.rpm[3];
    assign mode_now   = rq_head.mode;

    // a result is only produced into a queue with room
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        rq_push |-> !rq_full)
        else $error("result pushed into full result queue");

    // every tick taken by the back end yields exactly one result
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cq_pop && cq_head.op == OP_TICK) == rq_push)
        else $error("tick and result beat out of step");

    // the back end never pops from an empty command queue or into a full result queue
    a_cmd_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cq_pop |-> !cq_empty && !rq_full)
        else $error("command popped without data or result room");

    // a decoded beat enters the command queue only when the input side took it
    a_front_push: assert property (@(posedge clk) disable iff (!rst_n)
        cq_push |-> push && !full)
        else $error("command queue written without an accepted beat");

endmodule

@@ rtl/mms_queue.sv @@
// mms_queue: small register-based fifo for a packed payload type
// no package dependency; payload type given by parameter
`timescale 1ns / 1ps

module mms_queue #(
    parameter int  DEPTH  = 2,
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    output logic  full,
    input  logic  pop,
    output item_t pop_data,
    output logic  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/mms_front.sv @@
// mms_front: accepts event beats and decodes them into internal operations
// depends on mms_pkg
`timescale 1ns / 1ps

module mms_front (
    input  logic                           push,
    output logic                           full,
    input  logic [mms_pkg::KIND_W-1:0]     kind,
    input  logic [mms_pkg::TIME_W-1:0]     time_now_us,
    input  logic [mms_pkg::COUNT_W-1:0]    input_count,
    input  logic [mms_pkg::RPM_W-1:0]      rpm_a,
    input  logic [mms_pkg::RPM_W-1:0]      rpm_b,
    input  logic [mms_pkg::RPM_W-1:0]      rpm_c,
    input  logic [mms_pkg::RPM_W-1:0]      rpm_d,
    input  logic [mms_pkg::ARM_W-1:0]      arm_value,
    input  logic                           q_full,
    output logic                           q_push,
    output mms_pkg::item_t                 q_item
);

    import mms_pkg::*;

    logic keep;

    assign full = q_full;

    always_comb
    begin
        keep           = 1'b1;
        q_item.op      = OP_TICK;
        q_item.time_us = time_now_us;
        q_item.rpm[0]  = rpm_a;
        q_item.rpm[1]  = rpm_b;
        q_item.rpm[2]  = rpm_c;
        q_item.rpm[3]  = rpm_d;
        unique case (kind_t'(kind))
            KIND_TICK:
            begin
                q_item.op = OP_TICK;
            end
            KIND_RPM_CMD:
            begin
                q_item.op = OP_RPM_CMD;
                keep      = (input_count == COUNT_W'(MOTOR_COUNT));
            end
            KIND_CASC_CMD:
            begin
                q_item.op = OP_CASC_CMD;
            end
            KIND_MOTOR_STATE:
            begin
                q_item.op = (arm_value == ARM_ARM) ? OP_ARM : OP_DISARM;
                keep      = (arm_value == ARM_ARM) || (arm_value == ARM_DISARM);
            end
            KIND_GAINS_READY:
            begin
                q_item.op = OP_GAINS;
            end
            KIND_STATE_READY:
            begin
                q_item.op = OP_STATE;
            end
            KIND_EXT_CMD:
            begin
                q_item.op = OP_EXT;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // beats that change nothing are taken and dropped here
    assign q_push = push && !q_full && keep;

endmodule

@@ rtl/mms_back.sv @@
// mms_back: motor mode state machine, readiness flags and drive code
// depends on mms_pkg
`timescale 1ns / 1ps

module mms_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mms_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mms_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             q_empty,
    input  mms_pkg::item_t                   q_item,
    output logic                             q_pop,
    input  logic                             out_full,
    output logic                             out_push,
    output mms_pkg::result_t                 out_item
);

    import mms_pkg::*;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF     = 2'd0,
        MODE_START   = 2'd1,
        MODE_IDLE    = 2'd2,
        MODE_RUNNING = 2'd3
    } mode_t;

    mode_t              mode_reg, mode_next, mode_entry;
    logic               enabled_reg, enabled_next;
    logic               use_casc_reg, use_casc_next;
    logic               start_taken_reg, start_taken_next;
    logic [TIME_W-1:0]  start_time_reg, start_time_next;
    logic [TIME_W-1:0]  last_cmd_reg, last_cmd_next;
    rpm_vec_t           rpm_reg, rpm_next;
    logic               pending_reg, pending_next;
    logic               gains_reg, gains_next;
    logic               casc_ready_reg, casc_ready_next;
    logic               state_ready_reg, state_ready_next;
    logic [CFG_W-1:0]   start_dur_reg, start_dur_next;
    logic [CFG_W-1:0]   ttl_reg, ttl_next;

    logic [TIME_W-1:0]  start_base;
    logic [TIME_W-1:0]  cmd_stamp;
    logic [TIME_W-1:0]  start_elapsed;
    logic [TIME_W-1:0]  cmd_age;
    drive_t             code;

    assign q_pop    = !q_empty && !out_full;
    assign out_push = q_pop && (q_item.op == OP_TICK);

    assign start_base    = start_taken_reg ? start_time_reg : q_item.time_us;
    assign cmd_stamp     = pending_reg ? q_item.time_us : last_cmd_reg;
    assign start_elapsed = q_item.time_us - start_base;
    assign cmd_age       = q_item.time_us - cmd_stamp;

    always_comb
    begin
        if (!enabled_reg)
        begin
            mode_entry = MODE_OFF;
        end
        else if (mode_reg == MODE_OFF)
        begin
            mode_entry = MODE_START;
        end
        else
        begin
            mode_entry = mode_reg;
        end
    end

    always_comb
    begin
        mode_next        = mode_reg;
        enabled_next     = enabled_reg;
        use_casc_next    = use_casc_reg;
        start_taken_next = start_taken_reg;
        start_time_next  = start_time_reg;
        last_cmd_next    = last_cmd_reg;
        rpm_next         = rpm_reg;
        pending_next     = pending_reg;
        gains_next       = gains_reg;
        casc_ready_next  = casc_ready_reg;
        state_ready_next = state_ready_reg;
        start_dur_next   = start_dur_reg;
        ttl_next         = ttl_reg;
        code             = DRIVE_OFF;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_DURATION: start_dur_next = cfg_data;
                CFG_COMMAND_TTL:    ttl_next       = cfg_data;
                default:            ;
            endcase
        end

        if (q_pop)
        begin
            unique case (q_item.op)
                OP_RPM_CMD:
                begin
                    if (enabled_reg)
                    begin
                        rpm_next      = q_item.rpm;
                        use_casc_next = 1'b0;
                        pending_next  = 1'b1;
                    end
                end
                OP_CASC_CMD:
                begin
                    if (enabled_reg && gains_reg)
                    begin
                        casc_ready_next = 1'b1;
                        use_casc_next   = 1'b1;
                        pending_next    = 1'b1;
                    end
                end
                OP_ARM:    enabled_next     = 1'b1;
                OP_DISARM: enabled_next     = 1'b0;
                OP_GAINS:  gains_next       = 1'b1;
                OP_STATE:  state_ready_next = 1'b1;
                OP_EXT:    pending_next     = 1'b1;
                OP_TICK:
                begin
                    pending_next  = 1'b0;
                    last_cmd_next = cmd_stamp;
                    mode_next     = mode_entry;
                    unique case (mode_entry)
                        MODE_OFF:
                        begin
                            code            = DRIVE_OFF;
                            casc_ready_next = 1'b0;
                        end
                        MODE_START:
                        begin
                            code             = DRIVE_START;
                            start_taken_next = 1'b1;
                            start_time_next  = start_base;
                            if (start_elapsed > TIME_W'(start_dur_reg))
                            begin
                                start_taken_next = 1'b0;
                                mode_next        = MODE_IDLE;
                            end
                        end
                        MODE_IDLE:
                        begin
                            if (pending_reg)
                            begin
                                mode_next = MODE_RUNNING;
                                code      = DRIVE_HOLD;
                            end
                            else
                            begin
                                code = DRIVE_MIN;
                            end
                        end
                        MODE_RUNNING:
                        begin
                            priority if (cmd_age > TIME_W'(ttl_reg))
                            begin
                                mode_next = MODE_IDLE;
                                code      = DRIVE_HOLD;
                            end
                            else if (!use_casc_reg)
                            begin
                                code = DRIVE_RPM;
                            end
                            else if (state_ready_reg && casc_ready_reg && gains_reg)
                            begin
                                code = DRIVE_CASC;
                            end
                            else
                            begin
                                code = DRIVE_MIN;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    always_comb
    begin
        out_item.code = code;
        out_item.rpm  = (code == DRIVE_RPM) ? rpm_reg : '0;
        out_item.mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_OFF;
            enabled_reg     <= 1'b0;
            use_casc_reg    <= 1'b0;
            start_taken_reg <= 1'b0;
            start_time_reg  <= '0;
            last_cmd_reg    <= '0;
            rpm_reg         <= '0;
            pending_reg     <= 1'b0;
            gains_reg       <= 1'b0;
            casc_ready_reg  <= 1'b0;
            state_ready_reg <= 1'b0;
            start_dur_reg   <= START_DURATION_RESET;
            ttl_reg         <= COMMAND_TTL_RESET;
        end
        else
        begin
            mode_reg        <= mode_next;
            enabled_reg     <= enabled_next;
            use_casc_reg    <= use_casc_next;
            start_taken_reg <= start_taken_next;
            start_time_reg  <= start_time_next;
            last_cmd_reg    <= last_cmd_next;
            rpm_reg         <= rpm_next;
            pending_reg     <= pending_next;
            gains_reg       <= gains_next;
            casc_ready_reg  <= casc_ready_next;
            state_ready_reg <= state_ready_next;
            start_dur_reg   <= start_dur_next;
            ttl_reg         <= ttl_next;
        end
    end

endmodule

@@ sim/testbench.sv @@
// testbench: self-checking bench for motor_mode_sequencer, event beats in and drive beats out
// predicts each tick's drive code, rpms and mode in step with accepted beats
// depends on mms_pkg and the motor_mode_sequencer rtl
`timescale 1ns / 1ps

module testbench;
    import mms_pkg::*;

    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE   = 2'd3;
    localparam logic [KIND_W-1:0]      KIND_UNUSED = 3'd7;
    localparam logic [CFG_W-1:0]       CFG_MAX     = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0]      TIME_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BEATS   = 90;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [TIME_W-1:0]  now_us;
        logic [COUNT_W-1:0] count;
        rpm_vec_t           rpm;
        logic [ARM_W-1:0]   arm;
    } event_beat_t;

    typedef struct {
        drive_t            code;
        rpm_vec_t          rpm;
        logic [MODE_W-1:0] mode;
    } drive_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [KIND_W-1:0]      kind = '0;
    logic [TIME_W-1:0]      time_now_us = '0;
    logic [COUNT_W-1:0]     input_count = '0;
    logic [RPM_W-1:0]       rpm_a = '0;
    logic [RPM_W-1:0]       rpm_b = '0;
    logic [RPM_W-1:0]       rpm_c = '0;
    logic [RPM_W-1:0]       rpm_d = '0;
    logic [ARM_W-1:0]       arm_value = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [2:0]             drive_code;
    logic [RPM_W-1:0]       out_rpm_a;
    logic [RPM_W-1:0]       out_rpm_b;
    logic [RPM_W-1:0]       out_rpm_c;
    logic [RPM_W-1:0]       out_rpm_d;
    logic [MODE_W-1:0]      mode_now;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    event_beat_t pending_events[$];
    drive_beat_t expected_drive[$];
    event_beat_t drv_beat;
    logic        idle_on = 1'b1;
    int          fail_count = 0;
    int          cycle_count = 0;
    logic [TIME_W-1:0] clock_us = '0;

    // predicted sequencer state and registers
    logic [CFG_W-1:0]    dur_cfg = START_DURATION_RESET;
    logic [CFG_W-1:0]    ttl_cfg = COMMAND_TTL_RESET;
    logic [MODE_W-1:0]   p_mode = MODE_OFF;
    logic                p_enabled = 1'b0;
    logic                p_casc_mode = 1'b0;
    logic                p_start_taken = 1'b0;
    logic [TIME_W-1:0]   p_start_us = '0;
    logic [TIME_W-1:0]   p_last_cmd = '0;
    rpm_vec_t            p_rpm = '0;
    logic                p_pending = 1'b0;
    logic                p_gains = 1'b0;
    logic                p_casc_ready = 1'b0;
    logic                p_state = 1'b0;

    motor_mode_sequencer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .time_now_us(time_now_us),
        .input_count(input_count),
        .rpm_a(rpm_a),
        .rpm_b(rpm_b),
        .rpm_c(rpm_c),
        .rpm_d(rpm_d),
        .arm_value(arm_value),
        .empty(empty),
        .pop(pop),
        .drive_code(drive_code),
        .out_rpm_a(out_rpm_a),
        .out_rpm_b(out_rpm_b),
        .out_rpm_c(out_rpm_c),
        .out_rpm_d(out_rpm_d),
        .mode_now(mode_now),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void sequencer_step(input event_beat_t b);
        drive_beat_t r;
        logic        got_cmd;
        case (b.kind)
            KIND_RPM_CMD:
                if (p_enabled && b.count == COUNT_W'(MOTOR_COUNT))
                begin
                    p_rpm = b.rpm;
                    p_casc_mode = 1'b0;
                    p_pending = 1'b1;
                end
            KIND_CASC_CMD:
                if (p_enabled && p_gains)
                begin
                    p_casc_ready = 1'b1;
                    p_casc_mode = 1'b1;
                    p_pending = 1'b1;
                end
            KIND_MOTOR_STATE:
                if (b.arm == ARM_DISARM)
                    p_enabled = 1'b0;
                else if (b.arm == ARM_ARM)
                    p_enabled = 1'b1;
            KIND_GAINS_READY: p_gains = 1'b1;
            KIND_STATE_READY: p_state = 1'b1;
            KIND_EXT_CMD:     p_pending = 1'b1;
            KIND_TICK:
            begin
                r.code = DRIVE_OFF;
                r.rpm = '0;
                got_cmd = p_pending;
                p_pending = 1'b0;
                if (got_cmd)
                    p_last_cmd = b.now_us;
                if (p_enabled && p_mode == MODE_OFF)
                    p_mode = MODE_START;
                if (!p_enabled)
                    p_mode = MODE_OFF;
                case (p_mode)
                    MODE_START:
                    begin
                        if (!p_start_taken)
                        begin
                            p_start_taken = 1'b1;
                            p_start_us = b.now_us;
                        end
                        r.code = DRIVE_START;
                        if (b.now_us - p_start_us > {32'd0, dur_cfg})
                        begin
                            p_start_taken = 1'b0;
                            p_mode = MODE_IDLE;
                        end
                    end
                    MODE_OFF:
                    begin
                        r.code = DRIVE_OFF;
                        p_casc_ready = 1'b0;
                    end
                    MODE_IDLE:
                        if (got_cmd)
                        begin
                            p_mode = MODE_RUNNING;
                            r.code = DRIVE_HOLD;
                        end
                        else
                            r.code = DRIVE_MIN;
                    default:
                        if (b.now_us - p_last_cmd > {32'd0, ttl_cfg})
                        begin
                            p_mode = MODE_IDLE;
                            r.code = DRIVE_HOLD;
                        end
                        else if (!p_casc_mode)
                        begin
                            r.code = DRIVE_RPM;
                            r.rpm = p_rpm;
                        end
                        else if (p_state && p_casc_ready && p_gains)
                            r.code = DRIVE_CASC;
                        else
                            r.code = DRIVE_MIN;
                endcase
                r.mode = p_mode;
                expected_drive.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void queue_event(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                                        input logic [COUNT_W-1:0] n, input logic [ARM_W-1:0] a,
                                        input rpm_vec_t r);
        event_beat_t b;
        b.kind = k;
        b.now_us = t;
        b.count = n;
        b.arm = a;
        b.rpm = r;
        pending_events.push_back(b);
    endfunction

    // ticks on a mostly forward-running clock with commands between them, some of them malformed
    function automatic event_beat_t random_event(input int unsigned step_max);
        event_beat_t b;
        int unsigned pick;
        b.kind = KIND_TICK;
        b.now_us = {$urandom, $urandom};
        b.count = COUNT_W'($urandom_range(0, 15));
        b.rpm = {$urandom, $urandom};
        b.arm = ARM_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 49) == 0)
                clock_us = {$urandom, $urandom};
            else
                clock_us = clock_us + $urandom_range(0, step_max);
            b.now_us = clock_us;
        end
        else if (pick < 58)
        begin
            b.kind = KIND_RPM_CMD;
            if ($urandom_range(0, 5) != 0)
                b.count = COUNT_W'(MOTOR_COUNT);
        end
        else if (pick < 66)
            b.kind = KIND_CASC_CMD;
        else if (pick < 73)
            b.kind = KIND_EXT_CMD;
        else if (pick < 86)
        begin
            b.kind = KIND_MOTOR_STATE;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                b.arm = ARM_ARM;
            else if (pick < 9)
                b.arm = ARM_DISARM;
        end
        else if (pick < 91)
            b.kind = KIND_GAINS_READY;
        else if (pick < 96)
            b.kind = KIND_STATE_READY;
        else
            b.kind = KIND_UNUSED;
        return b;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_DURATION)
            dur_cfg = value;
        else if (idx == CFG_COMMAND_TTL)
            ttl_cfg = value;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || push || expected_drive.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] dur, input logic [CFG_W-1:0] ttl,
                             input int unsigned step_max, input logic with_idle);
        write_reg(CFG_START_DURATION, dur);
        write_reg(CFG_COMMAND_TTL, ttl);
        @(negedge clk);
        idle_on = with_idle;
        repeat (PHASE_BEATS) pending_events.push_back(random_event(step_max));
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic busy;
        int   gap_left;
        if (!rst_n)
        begin
            push <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            busy = push;
            if (push && !full)
            begin
                sequencer_step(drv_beat);
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_events.size() > 0)
                begin
                    if (idle_on && $urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(0, 14);
                    else
                    begin
                        drv_beat = pending_events.pop_front();
                        busy = 1'b1;
                        kind <= drv_beat.kind;
                        time_now_us <= drv_beat.now_us;
                        input_count <= drv_beat.count;
                        rpm_a <= drv_beat.rpm[0];
                        rpm_b <= drv_beat.rpm[1];
                        rpm_c <= drv_beat.rpm[2];
                        rpm_d <= drv_beat.rpm[3];
                        arm_value <= drv_beat.arm;
                    end
                end
            end
            push <= busy;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        drive_beat_t want;
        int          stall_left;
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_drive.size() == 0)
                begin
                    $error("drive beat with none expected: drive_code %0d", drive_code);
                    fail_count++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    check_field("drive_code", want.code, drive_code);
                    check_field("out_rpm_a", want.rpm[0], out_rpm_a);
                    check_field("out_rpm_b", want.rpm[1], out_rpm_b);
                    check_field("out_rpm_c", want.rpm[2], out_rpm_c);
                    check_field("out_rpm_d", want.rpm[3], out_rpm_d);
                    check_field("mode_now", want.mode, mode_now);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(CFG_START_DURATION, 32'd10);
        write_reg(CFG_COMMAND_TTL, 32'd20);
        // writes to a spare index must leave both registers alone
        write_reg(CFG_SPARE, CFG_MAX);
        @(negedge clk);

        queue_event(KIND_TICK, '0, '0, '0, '0);
        queue_event(KIND_UNUSED, TIME_MAX, 4'hF, 8'hFF, '1);
        queue_event(KIND_RPM_CMD, '0, 4'd4, '0, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0});
        queue_event(KIND_MOTOR_STATE, '0, '0, 8'hFF, '0);
        queue_event(KIND_TICK, 64'd1, '0, '0, '0);
        queue_event(KIND_MOTOR_STATE, '0, '0, ARM_ARM, '0);
        queue_event(KIND_RPM_CMD, '0, 4'd3, '0, '1);
        queue_event(KIND_RPM_CMD, '0, 4'd4, '0, {16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF});
        queue_event(KIND_TICK, 64'd100, '0, '0, '0);
        // disarm mid spin-up keeps the old start stamp
        queue_event(KIND_MOTOR_STATE, '0, '0, ARM_DISARM, '0);
        queue_event(KIND_TICK, 64'd105, '0, '0, '0);
        queue_event(KIND_MOTOR_STATE, '0, '0, ARM_ARM, '0);
        queue_event(KIND_TICK, 64'd200, '0, '0, '0);
        queue_event(KIND_TICK, 64'd201, '0, '0, '0);
        queue_event(KIND_EXT_CMD, '0, '0, '0, '0);
        queue_event(KIND_TICK, 64'd202, '0, '0, '0);
        queue_event(KIND_TICK, 64'd210, '0, '0, '0);
        queue_event(KIND_GAINS_READY, '0, '0, '0, '0);
        queue_event(KIND_CASC_CMD, '0, '0, '0, '0);
        queue_event(KIND_TICK, 64'd215, '0, '0, '0);
        queue_event(KIND_STATE_READY, '0, '0, '0, '0);
        queue_event(KIND_TICK, 64'd220, '0, '0, '0);
        queue_event(KIND_TICK, TIME_MAX, '0, '0, '0);
        queue_event(KIND_RPM_CMD, '0, 4'd4, '0, {16'h0004, 16'h0003, 16'h0002, 16'h0001});
        queue_event(KIND_TICK, 64'd3, '0, '0, '0);
        queue_event(KIND_TICK, 64'd10, '0, '0, '0);
        drain();

        clock_us = 64'd1000;
        run_phase(32'd20, 32'd30, 8, 1'b1);
        run_phase('0, '0, 3, 1'b1);
        run_phase(CFG_MAX, CFG_MAX, 1000, 1'b1);
        run_phase(START_DURATION_RESET, COMMAND_TTL_RESET, 60000, 1'b1);
        run_phase(32'd5, 32'd40, 10, 1'b0);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
